// File: sv/tlbp_pkg.sv
// Shared types, codes and the counter training rule for the two-level branch predictor.
// No dependencies; imported by the predictor top level.
package tlbp_pkg;

    // Fixed width of the global history register.
    localparam int GHIST_BITS = 16;

    // Counter states: low half predicts taken.
    typedef logic [1:0] t_ctr;
    localparam t_ctr CTR_STRONG_TAKEN     = 2'd0;
    localparam t_ctr CTR_STRONG_NOT_TAKEN = 2'd3;

    // Index modes of the mode register; only the gshare bit is decoded above mode 1.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_GLOBAL = 2'd0;
    localparam t_mode MODE_LOCAL  = 2'd1;
    localparam t_mode MODE_GSHARE = 2'd2;

    // Prediction and verdict of one branch.
    typedef struct packed {
        logic correct;
        logic predicted_taken;
    } t_result;

    function automatic logic ctr_predict(input t_ctr ctr);
        ctr_predict = !ctr[1];
    endfunction

    // Jump to the strong state when right, step toward the outcome when wrong.
    function automatic t_ctr ctr_train(input t_ctr ctr, input logic taken);
        logic pred;
        pred = !ctr[1];
        if (pred == taken) begin
            ctr_train = taken ? CTR_STRONG_TAKEN : CTR_STRONG_NOT_TAKEN;
        end else if (taken) begin
            ctr_train = ctr - 2'd1;
        end else begin
            ctr_train = ctr + 2'd1;
        end
    endfunction

endpackage

// File: sv/tlbp_ram.sv
// Single-port-write, single-port-read synchronous memory with a registered read.
// Stand-alone; holds the counter table and the local history table.
module tlbp_ram #(
    parameter int AddrBits = 8,
    parameter int DataBits = 2
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AddrBits-1:0] i_waddr,
    input  logic [DataBits-1:0] i_wdata,
    input  logic                i_re,
    input  logic [AddrBits-1:0] i_raddr,
    output logic [DataBits-1:0] o_rdata
);

    logic [DataBits-1:0] mem [2**AddrBits];
    logic [DataBits-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/two_level_branch_predictor_unit.sv
// Two-level branch predictor top level: sequencer, index selection and the two tables.
// Depends on tlbp_pkg and tlbp_ram.
//
//   channel   direction  handshake                           payload
//   s_axis    in         i_s_axis_tvalid / o_s_axis_tready    branch_pc, taken
//   m_axis    out        o_m_axis_tvalid / i_m_axis_tready    predicted_taken, correct
//   cfg       in         i_cfg_valid / o_cfg_ready            predictor_mode
//
// An item is read, looked up and written back in turn: the transaction edge reads the local
// history table, the lookup state reads the counter table at the selected index, and the
// update state writes both tables back. The counter read is chained after the history read.
// After reset a clearing pass zeroes both tables, with o_s_axis_tready low.
// A result that is not taken holds the next item in its write-back step.
module two_level_branch_predictor_unit
    import tlbp_pkg::*;
#(
    parameter int TABLE_INDEX_BITS       = 18,
    parameter int GLOBAL_HISTORY_BITS    = 10,
    parameter int LOCAL_HISTORY_BITS     = 13,
    parameter int LOCAL_TABLE_INDEX_BITS = 13,
    parameter int XOR_INDEX_BITS         = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] branch_pc, [32] taken, rest zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] predicted_taken, [1] correct, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data        // predictor_mode
);

    localparam int TIB  = TABLE_INDEX_BITS;
    localparam int LTIB = LOCAL_TABLE_INDEX_BITS;
    localparam int LHB  = LOCAL_HISTORY_BITS;
    localparam int GHB  = GLOBAL_HISTORY_BITS;
    localparam int CLR_BITS = (TIB > LTIB) ? TIB : LTIB;
    localparam logic [31:0] XOR_MASK = 32'((64'd1 << XOR_INDEX_BITS) - 64'd1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CLR_BITS-1:0]   r_clr_cnt;
    t_mode                 r_mode;
    logic [GHIST_BITS-1:0] r_ghist;
    logic [31:0]           r_addr;
    logic                  r_taken;
    logic [TIB-1:0]        r_idx;
    logic                  r_out_valid;
    t_result               r_out;

    logic           w_in_acc;
    logic           w_go;
    logic [LHB-1:0] w_lhist;
    t_ctr           w_ctr;
    logic [63:0]    w_cat_glb;
    logic [63:0]    w_cat_loc;
    logic [31:0]    w_xor;
    logic [TIB-1:0] w_idx;

    logic            w_ct_we;
    logic [TIB-1:0]  w_ct_waddr;
    t_ctr            w_ct_wdata;
    logic            w_lh_we;
    logic [LTIB-1:0] w_lh_waddr;
    logic [LHB-1:0]  w_lh_wdata;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go            = (r_state == ST_UPDATE) && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready     = 1'b1;

    // Index candidates for the three modes.
    always_comb begin
        w_cat_glb = ({32'd0, r_addr} << GHB) | 64'(r_ghist[GHB-1:0]);
        w_cat_loc = ({32'd0, r_addr} << LHB) | 64'(w_lhist);
        w_xor     = (r_addr ^ 32'(r_ghist)) & XOR_MASK;
        if ((r_mode & MODE_GSHARE) != MODE_GLOBAL) begin
            w_idx = w_xor[TIB-1:0];
        end else if (r_mode == MODE_LOCAL) begin
            w_idx = w_cat_loc[TIB-1:0];
        end else begin
            w_idx = w_cat_glb[TIB-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (&r_clr_cnt) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Table write ports: zero during the clearing pass, trained values on write-back.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_ct_we    = 1'b1;
            w_ct_waddr = r_clr_cnt[TIB-1:0];
            w_ct_wdata = CTR_STRONG_TAKEN;
            w_lh_we    = 1'b1;
            w_lh_waddr = r_clr_cnt[LTIB-1:0];
            w_lh_wdata = '0;
        end else begin
            w_ct_we    = w_go;
            w_ct_waddr = r_idx;
            w_ct_wdata = ctr_train(w_ctr, r_taken);
            w_lh_we    = w_go;
            w_lh_waddr = r_addr[LTIB-1:0];
            w_lh_wdata = {w_lhist[LHB-2:0], r_taken};
        end
    end

    tlbp_ram #(.AddrBits(LTIB), .DataBits(LHB)) u_lht (
        .i_clk   (i_clk),
        .i_we    (w_lh_we),
        .i_waddr (w_lh_waddr),
        .i_wdata (w_lh_wdata),
        .i_re    (w_in_acc),
        .i_raddr (i_s_axis_tdata[LTIB-1:0]),
        .o_rdata (w_lhist)
    );

    tlbp_ram #(.AddrBits(TIB), .DataBits(2)) u_ctr (
        .i_clk   (i_clk),
        .i_we    (w_ct_we),
        .i_waddr (w_ct_waddr),
        .i_wdata (w_ct_wdata),
        .i_re    (r_state == ST_LOOKUP),
        .i_raddr (w_idx),
        .o_rdata (w_ctr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_mode      <= MODE_GLOBAL;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (w_go) begin
                r_ghist     <= {r_ghist[GHIST_BITS-2:0], r_taken};
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr  <= i_s_axis_tdata[31:0];
            r_taken <= i_s_axis_tdata[32];
        end
        if (r_state == ST_LOOKUP) begin
            r_idx <= w_idx;
        end
        if (w_go) begin
            r_out.predicted_taken <= ctr_predict(w_ctr);
            r_out.correct         <= (ctr_predict(w_ctr) == r_taken);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

endmodule

// File: sv/tlbp_checker.sv
// Port-level checks for the two-level branch predictor, bound to its top level.
// Depends only on the top level's ports.
module tlbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    // Reset leaves no result pending and blocks input for the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("output valid or input ready right after reset");

    // One item in flight: an accepted transaction keeps the input closed while the item is in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A waiting input transaction holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=> i_s_axis_tvalid && $stable(i_s_axis_tdata))
        else $error("waiting input changed");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Padding bits of the result stay zero.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:2] == 6'd0)
        else $error("result padding not zero");

endmodule

bind two_level_branch_predictor_unit tlbp_checker u_tlbp_checker (.*);
